@@ sv/rba_pkg.sv @@
// ----------------------------------------------------------------------------
// rba_pkg
// Request codes and the command and status bundles that pass between the
// allocator controller and its datapath.
// ----------------------------------------------------------------------------
package rba_pkg;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_RESERVE = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  typedef struct packed {
    logic capture;
    logic clear;
    logic rd_slot;
    logic rd_scan;
    logic scan_next;
    logic wr_set;
    logic wr_clr;
    logic wr_alloc;
    logic out_echo;
    logic out_alloc;
    logic out_full;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       slot_in_range;
    logic       found;
    logic       last_word;
    logic       clear_done;
  } status_t;

endpackage

@@ sv/rba_datapath.sv @@
// ----------------------------------------------------------------------------
// rba_datapath
// Busy-flag memory, request registers, word scan with find-first-zero and
// the result register.
// ----------------------------------------------------------------------------
module rba_datapath #(
  parameter int NUM_REGS  = 256,
  parameter int WORD_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            in_mode,
  input  logic [7:0]            in_slot_index,
  input  rba_pkg::cmd_t         cmd,
  output rba_pkg::status_t      status,
  output logic [7:0]            out_granted_index,
  output logic                  out_no_free
);

  localparam int NUM_WORDS = (NUM_REGS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int IDX_W     = $clog2(NUM_REGS) + 1;
  localparam int SUM_W     = (IDX_W > 8) ? IDX_W : 8;
  localparam int LAST_BITS = NUM_REGS - (NUM_WORDS - 1) * WORD_BITS;
  localparam logic [WORD_BITS-1:0] LAST_MASK =
    {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);

  logic [WORD_BITS-1:0] busy_mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rd_data_r;

  logic [1:0]      mode_r;
  logic [7:0]      slot_r;
  logic [WA_W-1:0] scan_addr_r, scan_addr_nxt;
  logic [IDX_W-1:0] base_r, base_nxt;
  logic [WA_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [7:0]      granted_r;
  logic            no_free_r;

  logic [WA_W-1:0]  word_tab [256];
  logic [BIT_W-1:0] bit_tab  [256];

  for (genvar v = 0; v < 256; v++) begin : g_tab
    assign word_tab[v] = WA_W'(v / WORD_BITS);
    assign bit_tab[v]  = BIT_W'(v % WORD_BITS);
  end

  logic [WA_W-1:0]      slot_word;
  logic [WORD_BITS-1:0] slot_mask;
  logic [WORD_BITS-1:0] valid_mask;
  logic [WORD_BITS-1:0] free_bits;
  logic [BIT_W-1:0]     ffz_bit;
  logic [WORD_BITS-1:0] ffz_mask;
  logic [SUM_W-1:0]     alloc_idx;

  assign slot_word  = word_tab[slot_r];
  assign slot_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_tab[slot_r];
  assign valid_mask = (scan_addr_r == WA_W'(NUM_WORDS - 1)) ? LAST_MASK
                                                            : {WORD_BITS{1'b1}};
  assign free_bits  = ~rd_data_r & valid_mask;
  assign ffz_mask   = {{(WORD_BITS-1){1'b0}}, 1'b1} << ffz_bit;
  assign alloc_idx  = SUM_W'(base_r) + SUM_W'(ffz_bit);

  always_comb begin
    ffz_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        ffz_bit = BIT_W'(b);
      end
    end
  end

  always_comb begin
    status.mode          = mode_r;
    status.slot_in_range = SUM_W'(slot_r) < SUM_W'(NUM_REGS);
    status.found         = |free_bits;
    status.last_word     = scan_addr_r == WA_W'(NUM_WORDS - 1);
    status.clear_done    = clr_cnt_r == WA_W'(NUM_WORDS - 1);
  end

  always_comb begin
    scan_addr_nxt = scan_addr_r;
    base_nxt      = base_r;
    clr_cnt_nxt   = clr_cnt_r;
    if (cmd.capture) begin
      scan_addr_nxt = '0;
      base_nxt      = '0;
    end else if (cmd.scan_next) begin
      scan_addr_nxt = scan_addr_r + 1'b1;
      base_nxt      = base_r + IDX_W'(WORD_BITS);
    end
    if (cmd.clear) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_addr_r <= scan_addr_nxt;
    base_r      <= base_nxt;
    if (cmd.capture) begin
      mode_r <= in_mode;
      slot_r <= in_slot_index;
    end
    if (cmd.out_echo) begin
      granted_r <= slot_r;
      no_free_r <= 1'b0;
    end else if (cmd.out_alloc) begin
      granted_r <= alloc_idx[7:0];
      no_free_r <= 1'b0;
    end else if (cmd.out_full) begin
      granted_r <= '0;
      no_free_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      busy_mem[clr_cnt_r] <= '0;
    end else if (cmd.wr_set) begin
      busy_mem[slot_word] <= rd_data_r | slot_mask;
    end else if (cmd.wr_clr) begin
      busy_mem[slot_word] <= rd_data_r & ~slot_mask;
    end else if (cmd.wr_alloc) begin
      busy_mem[scan_addr_r] <= rd_data_r | ffz_mask;
    end
    if (cmd.rd_slot) begin
      rd_data_r <= busy_mem[slot_word];
    end else if (cmd.rd_scan) begin
      rd_data_r <= busy_mem[scan_addr_r];
    end
  end

  assign out_granted_index = granted_r;
  assign out_no_free       = no_free_r;

endmodule

@@ sv/rba_ctrl.sv @@
// ----------------------------------------------------------------------------
// rba_ctrl
// Sequencer for the allocator: clearing pass, request dispatch, word scan,
// write-back and the result valid flag.
// ----------------------------------------------------------------------------
module rba_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  rba_pkg::status_t      status,
  output rba_pkg::cmd_t         cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DISP  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       is_alloc;

  assign out_free = !out_valid_r || out_ready;
  assign is_alloc = status.mode == rba_pkg::MODE_ALLOC;
  assign in_ready = state_r == S_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        if (is_alloc) begin
          state_nxt = S_SCAN;
        end else if ((status.mode == rba_pkg::MODE_RESERVE ||
                      status.mode == rba_pkg::MODE_RELEASE) &&
                     status.slot_in_range) begin
          cmd.rd_slot = 1'b1;
          state_nxt   = S_CHK;
        end else if (out_free) begin
          cmd.out_echo = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.rd_scan = 1'b1;
        state_nxt   = S_CHK;
      end
      S_CHK: begin
        if (is_alloc) begin
          if (status.found) begin
            if (out_free) begin
              cmd.wr_alloc  = 1'b1;
              cmd.out_alloc = 1'b1;
              state_nxt     = S_IDLE;
            end
          end else if (status.last_word) begin
            if (out_free) begin
              cmd.out_full = 1'b1;
              state_nxt    = S_IDLE;
            end
          end else begin
            cmd.scan_next = 1'b1;
            state_nxt     = S_SCAN;
          end
        end else if (out_free) begin
          cmd.wr_set   = status.mode == rba_pkg::MODE_RESERVE;
          cmd.wr_clr   = status.mode == rba_pkg::MODE_RELEASE;
          cmd.out_echo = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_echo || cmd.out_alloc || cmd.out_full) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !(cmd.clear || cmd.wr_set || cmd.wr_clr || cmd.wr_alloc))
    else $error("busy memory written while idle");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_DISP)
    else $error("accepted request not dispatched");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.out_echo, cmd.out_alloc, cmd.out_full}))
    else $error("more than one result source loaded");

  a_result_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !(cmd.out_echo || cmd.out_alloc || cmd.out_full))
    else $error("pending result overwritten");

  a_scan_advance: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHK && is_alloc && !status.found && !status.last_word
    |=> state_r == S_SCAN)
    else $error("scan did not advance to next word");
`endif

endmodule

@@ sv/register_bitmap_allocator.sv @@
// ----------------------------------------------------------------------------
// register_bitmap_allocator
// Lowest-free-first allocator over NUM_REGS busy flags held in a word memory.
//
//   channel  direction  ports
//   in       input      in_valid, in_ready, in_mode, in_slot_index
//   out      output     out_valid, out_ready, out_granted_index, out_no_free
//
// Reserve or release of an index in range passes dispatch, a slot read and a
// check with write-back before the result; an unknown mode or an out-of-range
// index is echoed from dispatch. Allocate alternates a word read and a check
// of that word, from word 0 up, until a free flag or the last word is found.
// After reset a clearing pass over all NUM_WORDS words runs with in_ready low.
// A stalled result holds the write-back until it drains.
// ----------------------------------------------------------------------------
module register_bitmap_allocator #(
  parameter int NUM_REGS  = 256,
  parameter int WORD_BITS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_slot_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_granted_index,
  output logic       out_no_free
);

  rba_pkg::cmd_t    cmd;
  rba_pkg::status_t status;

  rba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rba_datapath #(
    .NUM_REGS  (NUM_REGS),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_mode           (in_mode),
    .in_slot_index     (in_slot_index),
    .cmd               (cmd),
    .status            (status),
    .out_granted_index (out_granted_index),
    .out_no_free       (out_no_free)
  );

endmodule
